// ----- design/tch_pkg.sv -----
// shared types, constants and helper functions for the tilt compensated compass heading block
package tch_pkg;

    localparam int CW_XY = 56;
    localparam int CW_Z = 34;
    localparam int MUL_A = 35;
    localparam int MUL_B = 29;
    localparam int MUL_P = 64;
    localparam int SC_W = 18;

    localparam logic signed [CW_XY-1:0] CORDIC_GAIN_Q30 = 56'sd652032874;
    localparam logic signed [CW_Z-1:0] PI_Q29 = 34'sd1686629713;
    localparam logic signed [CW_XY-1:0] NORM_LIMIT = 56'sd1099511627776;
    localparam logic signed [CW_XY-1:0] COARSE_LIMIT = 56'sd4294967296;
    localparam logic signed [16:0] IN_PI = 17'sd25736;
    localparam logic signed [16:0] IN_HALF_PI = 17'sd12868;
    localparam logic signed [16:0] IN_TWO_PI = 17'sd51472;
    localparam logic signed [MUL_B-1:0] DEG_SCALE = 29'sd240315917;
    localparam logic signed [17:0] PLAIN_WRAP = 18'sd51472;
    localparam logic signed [17:0] PLAIN_MAX = 18'sd51471;
    localparam logic signed [MUL_P-1:0] DEG_MAX = 64'sd11520;

    localparam int ATAN_LEN = 24;
    localparam logic [30:0] ATAN_Q29 [ATAN_LEN] = '{
        31'd421657428, 31'd248918915, 31'd131521918, 31'd66762579, 31'd33510843,
        31'd16771758, 31'd8387925, 31'd4194219, 31'd2097141, 31'd1048575,
        31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768, 31'd16384,
        31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256, 31'd128, 31'd64
    };

    typedef enum logic [1:0] {
        CFG_FORWARD = 2'd0,
        CFG_RIGHT   = 2'd1,
        CFG_UP      = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        AX_X = 2'd0,
        AX_Y = 2'd1,
        AX_Z = 2'd2
    } t_axis;

    typedef enum logic {
        COR_ROTATE = 1'b0,
        COR_VECTOR = 1'b1
    } t_cor_mode;

    typedef struct packed {
        logic      start;
        t_cor_mode mode;
    } t_cor_ctl;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_NORM,
        CS_FOLD,
        CS_ITER,
        CS_DONE
    } t_cor_state;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PITCH,
        S_W_PITCH,
        S_ROLL,
        S_W_ROLL,
        S_PLAIN,
        S_W_PLAIN,
        S_MUL,
        S_TILT,
        S_W_TILT,
        S_DEG,
        S_RND,
        S_OUT
    } t_state;

    typedef struct packed {
        logic signed [15:0] ang;
        logic               neg;
    } t_fold;

    function automatic logic signed [15:0] pick_axis(
        input logic [2:0] code,
        input logic signed [15:0] sx,
        input logic signed [15:0] sy,
        input logic signed [15:0] sz
    );
        logic signed [15:0] v;
        v = '0;
        unique case (t_axis'(code[2:1]))
            AX_X: v = sx;
            AX_Y: v = sy;
            AX_Z: v = sz;
            default: v = '0;
        endcase
        if (code[0]) begin
            v = (v == 16'sh8000) ? 16'sh7fff : -v;
        end
        return v;
    endfunction

    function automatic t_fold fold_angle(input logic signed [15:0] a);
        logic signed [16:0] w;
        t_fold f;
        w = 17'(a);
        if (w > IN_PI) begin
            w = w - IN_TWO_PI;
        end else if (w < -IN_PI) begin
            w = w + IN_TWO_PI;
        end
        f.neg = 1'b0;
        if (w > IN_HALF_PI) begin
            w = w - IN_PI;
            f.neg = 1'b1;
        end else if (w < -IN_HALF_PI) begin
            w = w + IN_PI;
            f.neg = 1'b1;
        end
        f.ang = 16'(w);
        return f;
    endfunction

    // round half away from zero
    function automatic logic signed [63:0] round_shift(
        input logic signed [63:0] v,
        input int unsigned s
    );
        logic [63:0] mag;
        logic [63:0] half;
        half = 64'd1 << (s - 1);
        mag = (v < 0) ? 64'(-v) : 64'(v);
        mag = (mag + half) >> s;
        return (v < 0) ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

// ----- design/tilt_compensated_compass_heading.sv -----
// top level of the tilt compensated compass heading block
//
//  channel | valid       | stall        | payload
//  input   | i_in_valid  | o_in_stall   | i_sensor_x/y/z, i_pitch_angle, i_roll_angle
//  output  | o_out_valid | i_out_stall  | o_plain_heading, o_tilt_heading
//  config  | i_cfg_we    | none         | i_cfg_index, i_cfg_data
//
// one word makes four passes through the single shared cordic unit
// and also uses the shared multiplier
// o_in_stall is high from accept until the result is moved into the output register
// a finished result waits in the output register so the next word can be taken
// synchronous active-low reset clears windows, running sums, slot, state and output valid, and resets axis selects
module tilt_compensated_compass_heading #(
    parameter int WINDOW_DEPTH = 4,
    parameter int CORDIC_STEPS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [2:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_sensor_x,
    input  logic signed [15:0] i_sensor_y,
    input  logic signed [15:0] i_sensor_z,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_roll_angle,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [15:0]        o_plain_heading,
    output logic signed [14:0] o_tilt_heading
);
    import tch_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_DEPTH);
    localparam int SUM_W = 16 + $clog2(WINDOW_DEPTH);

    t_state r_state, n_state;
    logic [2:0] r_fwd_src, r_rgt_src, r_up_src;
    logic signed [15:0] r_fwin [WINDOW_DEPTH];
    logic signed [15:0] r_rwin [WINDOW_DEPTH];
    logic signed [15:0] r_uwin [WINDOW_DEPTH];
    logic [SLOT_W-1:0] r_slot;
    logic signed [SUM_W-1:0] r_fsum, r_rsum, r_usum;
    logic signed [15:0] r_pitch, r_roll;
    logic signed [SC_W-1:0] r_sp, r_cp, r_sr, r_cr;
    logic signed [MUL_A-1:0] r_p0, r_p1;
    logic signed [CW_XY-1:0] r_xc, r_yc;
    logic signed [MUL_P-1:0] r_prod;
    logic signed [CW_Z-1:0] r_ang;
    logic [2:0] r_k;
    logic [15:0] r_plain_pend;
    logic signed [14:0] r_tilt_pend;
    logic r_out_valid;
    logic [15:0] r_plain;
    logic signed [14:0] r_tilt;

    logic in_acc, out_free;
    logic signed [15:0] nf, nr, nu;
    t_fold fold_p, fold_r, fold_c;
    t_cor_ctl cor_ctl;
    logic signed [CW_XY-1:0] cor_xi, cor_yi, cor_xo, cor_yo;
    logic signed [CW_Z-1:0] cor_zi, cor_zo;
    logic cor_done;
    logic signed [MUL_A-1:0] mul_a;
    logic signed [MUL_B-1:0] mul_b;
    logic signed [SC_W-1:0] rc, rs;
    logic signed [17:0] ph;
    logic signed [MUL_P-1:0] dg;

    assign in_acc = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    assign nf = pick_axis(r_fwd_src, i_sensor_x, i_sensor_y, i_sensor_z);
    assign nr = pick_axis(r_rgt_src, i_sensor_x, i_sensor_y, i_sensor_z);
    assign nu = pick_axis(r_up_src, i_sensor_x, i_sensor_y, i_sensor_z);
    assign fold_p = fold_angle(r_pitch);
    assign fold_r = fold_angle(r_roll);
    assign fold_c = (r_state == S_W_PITCH) ? fold_p : fold_r;

    // sin and cos from the rotation result, plain angle from the vectoring result, tilt degrees from the product
    assign rc = SC_W'(round_shift(64'(cor_xo), 15));
    assign rs = SC_W'(round_shift(64'(cor_yo), 15));
    assign ph = 18'(round_shift(64'(cor_zo), 16));
    assign dg = round_shift(r_prod, 45);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_src <= 3'd0;
            r_rgt_src <= 3'd2;
            r_up_src <= 3'd4;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FORWARD: r_fwd_src <= i_cfg_data;
                CFG_RIGHT:   r_rgt_src <= i_cfg_data;
                CFG_UP:      r_up_src <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_fwin[i] <= '0;
                r_rwin[i] <= '0;
                r_uwin[i] <= '0;
            end
            r_slot <= '0;
            r_fsum <= '0;
            r_rsum <= '0;
            r_usum <= '0;
        end else if (in_acc) begin
            r_fwin[r_slot] <= nf;
            r_rwin[r_slot] <= nr;
            r_uwin[r_slot] <= nu;
            r_fsum <= r_fsum - SUM_W'(r_fwin[r_slot]) + SUM_W'(nf);
            r_rsum <= r_rsum - SUM_W'(r_rwin[r_slot]) + SUM_W'(nr);
            r_usum <= r_usum - SUM_W'(r_uwin[r_slot]) + SUM_W'(nu);
            r_slot <= (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        cor_ctl = '{start: 1'b0, mode: COR_ROTATE};
        cor_xi = CORDIC_GAIN_Q30;
        cor_yi = '0;
        cor_zi = '0;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_PITCH;
            S_PITCH: begin
                cor_ctl.start = 1'b1;
                cor_zi = CW_Z'(fold_p.ang) <<< 16;
                n_state = S_W_PITCH;
            end
            S_W_PITCH: if (cor_done) n_state = S_ROLL;
            S_ROLL: begin
                cor_ctl.start = 1'b1;
                cor_zi = CW_Z'(fold_r.ang) <<< 16;
                n_state = S_W_ROLL;
            end
            S_W_ROLL: if (cor_done) n_state = S_PLAIN;
            S_PLAIN: begin
                cor_ctl = '{start: 1'b1, mode: COR_VECTOR};
                cor_xi = CW_XY'(r_fsum);
                cor_yi = CW_XY'(r_rsum);
                n_state = S_W_PLAIN;
            end
            S_W_PLAIN: if (cor_done) n_state = S_MUL;
            S_MUL: if (r_k == 3'd7) n_state = S_TILT;
            S_TILT: begin
                cor_ctl = '{start: 1'b1, mode: COR_VECTOR};
                cor_xi = r_xc <<< 15;
                cor_yi = r_yc;
                n_state = S_W_TILT;
            end
            S_W_TILT: if (cor_done) n_state = S_DEG;
            S_DEG: n_state = S_RND;
            S_RND: n_state = S_OUT;
            S_OUT: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == S_DEG) begin
            mul_a = MUL_A'(r_ang);
            mul_b = DEG_SCALE;
        end else begin
            unique case (r_k)
                3'd0: begin mul_a = MUL_A'(r_sr); mul_b = MUL_B'(r_sp); end
                3'd1: begin mul_a = MUL_A'(r_sr); mul_b = MUL_B'(r_cp); end
                3'd2: begin mul_a = r_p0; mul_b = MUL_B'(r_fsum); end
                3'd3: begin mul_a = MUL_A'(r_cr); mul_b = MUL_B'(r_rsum); end
                3'd4: begin mul_a = r_p1; mul_b = MUL_B'(r_usum); end
                3'd5: begin mul_a = MUL_A'(r_cp); mul_b = MUL_B'(r_fsum); end
                3'd6: begin mul_a = MUL_A'(r_sp); mul_b = MUL_B'(r_usum); end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P'(mul_a) * MUL_P'(mul_b);
        if (in_acc) begin
            r_pitch <= i_pitch_angle;
            r_roll <= i_roll_angle;
        end
        if (r_state == S_W_PITCH && cor_done) begin
            r_cp <= fold_c.neg ? -rc : rc;
            r_sp <= fold_c.neg ? -rs : rs;
        end
        if (r_state == S_W_ROLL && cor_done) begin
            r_cr <= fold_c.neg ? -rc : rc;
            r_sr <= fold_c.neg ? -rs : rs;
        end
        if (r_state == S_W_PLAIN && cor_done) begin
            if (ph < 0) begin
                r_plain_pend <= 16'(ph + PLAIN_WRAP);
            end else if (ph > PLAIN_MAX) begin
                r_plain_pend <= 16'(PLAIN_MAX);
            end else begin
                r_plain_pend <= 16'(ph);
            end
        end
        if (r_state == S_W_TILT && cor_done) begin
            r_ang <= cor_zo;
        end
        if (r_state == S_MUL) begin
            r_k <= r_k + 1'b1;
            unique case (r_k)
                3'd1: r_p0 <= MUL_A'(r_prod);
                3'd2: r_p1 <= MUL_A'(r_prod);
                3'd3: r_yc <= CW_XY'(r_prod);
                3'd4: r_yc <= r_yc + (CW_XY'(r_prod) <<< 15);
                3'd5: r_yc <= r_yc - CW_XY'(r_prod);
                3'd6: r_xc <= CW_XY'(r_prod);
                3'd7: r_xc <= r_xc + CW_XY'(r_prod);
                default: begin
                end
            endcase
        end else begin
            r_k <= '0;
        end
        if (r_state == S_RND) begin
            if (dg > DEG_MAX) begin
                r_tilt_pend <= 15'(DEG_MAX);
            end else if (dg < -DEG_MAX) begin
                r_tilt_pend <= 15'(-DEG_MAX);
            end else begin
                r_tilt_pend <= 15'(dg);
            end
        end
        if (r_state == S_OUT && out_free) begin
            r_plain <= r_plain_pend;
            r_tilt <= r_tilt_pend;
        end
    end

    tch_cordic #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (cor_ctl),
        .i_x     (cor_xi),
        .i_y     (cor_yi),
        .i_z     (cor_zi),
        .o_x     (cor_xo),
        .o_y     (cor_yo),
        .o_z     (cor_zo),
        .o_done  (cor_done)
    );

    assign o_out_valid = r_out_valid;
    assign o_plain_heading = r_plain;
    assign o_tilt_heading = r_tilt;

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cor_done |-> (r_state == S_W_PITCH || r_state == S_W_ROLL
                   || r_state == S_W_PLAIN || r_state == S_W_TILT))
        else $error("cordic done outside a wait state");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_PITCH))
        else $error("accepted word did not start the sequence");

    a_plain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_plain_heading <= 16'd51471))
        else $error("plain heading out of range");

    a_tilt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_tilt_heading <= 15'sd11520 && o_tilt_heading >= -15'sd11520))
        else $error("tilt heading out of range");

endmodule

// ----- design/tch_cordic.sv -----
// shared iterative cordic unit for rotation (sin/cos) and vectoring (atan2)
module tch_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tch_pkg::t_cor_ctl                   i_ctl,
    input  logic signed [tch_pkg::CW_XY-1:0]    i_x,
    input  logic signed [tch_pkg::CW_XY-1:0]    i_y,
    input  logic signed [tch_pkg::CW_Z-1:0]     i_z,
    output logic signed [tch_pkg::CW_XY-1:0]    o_x,
    output logic signed [tch_pkg::CW_XY-1:0]    o_y,
    output logic signed [tch_pkg::CW_Z-1:0]     o_z,
    output logic                                o_done
);
    import tch_pkg::*;

    localparam int CNT_W = $clog2(CORDIC_STEPS);
    localparam int TAB_W = $clog2(ATAN_LEN);

    t_cor_state r_state, n_state;
    t_cor_mode r_mode;
    logic [CNT_W-1:0] r_cnt;
    logic signed [CW_XY-1:0] r_x, r_y;
    logic signed [CW_Z-1:0] r_z;

    logic signed [CW_XY-1:0] xs, ys;
    logic signed [CW_Z-1:0] at;
    logic dir;
    logic is_zero, is_big, is_tiny, last;

    assign xs = r_x >>> r_cnt;
    assign ys = r_y >>> r_cnt;
    assign at = CW_Z'(ATAN_Q29[TAB_W'(r_cnt)]);
    assign dir = (r_mode == COR_ROTATE) ? (r_z >= 0) : (r_y < 0);
    assign is_zero = (r_x == 0) && (r_y == 0);
    assign is_big = (r_x >= NORM_LIMIT) || (r_x <= -NORM_LIMIT)
                 || (r_y >= NORM_LIMIT) || (r_y <= -NORM_LIMIT);
    assign is_tiny = (r_x < COARSE_LIMIT) && (r_x > -COARSE_LIMIT)
                  && (r_y < COARSE_LIMIT) && (r_y > -COARSE_LIMIT);
    assign last = (r_cnt == CNT_W'(CORDIC_STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_done = 1'b0;
        unique case (r_state)
            CS_IDLE: begin
                if (i_ctl.start) begin
                    n_state = (i_ctl.mode == COR_VECTOR) ? CS_NORM : CS_ITER;
                end
            end
            CS_NORM: begin
                if (is_zero || is_big) begin
                    n_state = CS_FOLD;
                end
            end
            CS_FOLD: n_state = CS_ITER;
            CS_ITER: begin
                if (last) begin
                    n_state = CS_DONE;
                end
            end
            CS_DONE: begin
                o_done = 1'b1;
                n_state = CS_IDLE;
            end
            default: n_state = CS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            CS_IDLE: begin
                r_x <= i_x;
                r_y <= i_y;
                r_z <= i_z;
                r_mode <= i_ctl.mode;
                r_cnt <= '0;
            end
            CS_NORM: begin
                if (!(is_zero || is_big)) begin
                    if (is_tiny) begin
                        r_x <= r_x <<< 8;
                        r_y <= r_y <<< 8;
                    end else begin
                        r_x <= r_x <<< 1;
                        r_y <= r_y <<< 1;
                    end
                end
            end
            CS_FOLD: begin
                if (r_x < 0) begin
                    r_z <= (r_y >= 0) ? PI_Q29 : -PI_Q29;
                    r_x <= -r_x;
                    r_y <= -r_y;
                end
            end
            CS_ITER: begin
                if (r_mode == COR_ROTATE || r_y != 0) begin
                    if (dir) begin
                        r_x <= r_x - ys;
                        r_y <= r_y + xs;
                        r_z <= r_z - at;
                    end else begin
                        r_x <= r_x + ys;
                        r_y <= r_y - xs;
                        r_z <= r_z + at;
                    end
                end
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

// ----- verif/tb_tilt_compensated_compass_heading.sv -----
// testbench for the tilt compensated compass heading block: directed table plus random words
`timescale 1ns / 1ps

module tb_tilt_compensated_compass_heading;
    import tch_pkg::*;

    localparam int WIN = 4;
    localparam int STEPS = 16;
    localparam int N_ROWS = 15;
    localparam int N_PHASES = 8;
    localparam int WORDS_PER_PHASE = 240;
    localparam int IDLE_LIMIT = 5000;

    typedef struct {
        logic        [15:0] plain;
        logic signed [14:0] tilt;
    } t_heading;

    typedef struct {
        int x;
        int y;
        int z;
        int p;
        int r;
        bit typed;
        int plain;
        int tilt;
    } t_row;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [2:0]         i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [15:0] i_sensor_x;
    logic signed [15:0] i_sensor_y;
    logic signed [15:0] i_sensor_z;
    logic signed [15:0] i_pitch_angle;
    logic signed [15:0] i_roll_angle;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [15:0]        o_plain_heading;
    logic signed [14:0] o_tilt_heading;

    t_heading    heading_q[$];
    logic [2:0]  fwd_src;
    logic [2:0]  right_src;
    logic [2:0]  up_src;
    longint      fwd_win[WIN];
    longint      right_win[WIN];
    longint      up_win[WIN];
    int          win_slot;
    int          errors;
    int          words_in;
    int          words_out;
    int          idle_cycles;
    int          stall_mode;
    int          burst_left;
    int          gap_max;

    tilt_compensated_compass_heading #(
        .WINDOW_DEPTH(WIN),
        .CORDIC_STEPS(STEPS)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sensor_x     (i_sensor_x),
        .i_sensor_y     (i_sensor_y),
        .i_sensor_z     (i_sensor_z),
        .i_pitch_angle  (i_pitch_angle),
        .i_roll_angle   (i_roll_angle),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_plain_heading(o_plain_heading),
        .o_tilt_heading (o_tilt_heading)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    function automatic longint round_away(input longint v, input int s);
        longint half;
        half = longint'(1) << (s - 1);
        if (v >= 0) begin
            return (v + half) >>> s;
        end
        return -(((-v) + half) >>> s);
    endfunction

    function automatic longint axis_value(input logic [2:0] code, input int sx, input int sy,
                                          input int sz);
        longint v;
        case (code[2:1])
            2'd0: v = sx;
            2'd1: v = sy;
            2'd2: v = sz;
            default: v = 0;
        endcase
        if (code[0]) begin
            v = (v == -32768) ? 32767 : -v;
        end
        return v;
    endfunction

    function automatic void sin_cos_q15(input int a, output longint s, output longint c);
        bit     neg;
        longint x;
        longint y;
        longint z;
        longint nx;
        neg = 1'b0;
        x = longint'(CORDIC_GAIN_Q30);
        y = 0;
        if (a > 25736) a -= 51472;
        if (a < -25736) a += 51472;
        if (a > 12868) begin
            a -= 25736;
            neg = 1'b1;
        end else if (a < -12868) begin
            a += 25736;
            neg = 1'b1;
        end
        z = longint'(a) * 65536;
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(ATAN_Q29[i]);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(ATAN_Q29[i]);
            end
            x = nx;
        end
        x = round_away(x, 15);
        y = round_away(y, 15);
        c = neg ? -x : x;
        s = neg ? -y : y;
    endfunction

    function automatic longint vector_angle(input longint y, input longint x);
        longint m;
        longint z;
        longint nx;
        longint ax;
        longint ay;
        z = 0;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        m = (ax > ay) ? ax : ay;
        if (m == 0) begin
            return 0;
        end
        while (m < (longint'(1) << 40)) begin
            x *= 2;
            y *= 2;
            m *= 2;
        end
        if (x < 0) begin
            z = (y >= 0) ? longint'(PI_Q29) : -longint'(PI_Q29);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (y == 0) break;
            if (y > 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(ATAN_Q29[i]);
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(ATAN_Q29[i]);
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic t_heading predict_heading(input int sx, input int sy, input int sz,
                                                 input int p, input int r);
        longint   fs;
        longint   rs;
        longint   us;
        longint   sp;
        longint   cp;
        longint   sr;
        longint   cr;
        longint   xc;
        longint   yc;
        longint   ang;
        longint   ph;
        longint   deg;
        t_heading h;
        fwd_win[win_slot] = axis_value(fwd_src, sx, sy, sz);
        right_win[win_slot] = axis_value(right_src, sx, sy, sz);
        up_win[win_slot] = axis_value(up_src, sx, sy, sz);
        win_slot = (win_slot + 1) % WIN;
        fs = 0;
        rs = 0;
        us = 0;
        for (int i = 0; i < WIN; i++) begin
            fs += fwd_win[i];
            rs += right_win[i];
            us += up_win[i];
        end
        ang = vector_angle(rs, fs);
        ph = round_away(ang, 16);
        if (ph < 0) ph += 51472;
        if (ph > 51471) ph = 51471;
        sin_cos_q15(p, sp, cp);
        sin_cos_q15(r, sr, cr);
        xc = (fs * cp + us * sp) * 32768;
        yc = fs * (sr * sp) + rs * (cr * 32768) - us * (sr * cp);
        ang = vector_angle(yc, xc);
        deg = round_away(ang * longint'(DEG_SCALE), 45);
        if (deg > 11520) deg = 11520;
        if (deg < -11520) deg = -11520;
        h.plain = 16'(ph);
        h.tilt = 15'(deg);
        return h;
    endfunction

    // receiver stall pattern
    always @(posedge i_clk) begin
        case (stall_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 2) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_heading e;
        if (o_out_valid && !i_out_stall) begin
            words_out++;
            if (heading_q.size() == 0) begin
                $display("%0t unexpected word: plain %0d tilt %0d", $time,
                         o_plain_heading, o_tilt_heading);
                errors++;
            end else begin
                e = heading_q.pop_front();
                if (o_plain_heading !== e.plain) begin
                    $display("%0t plain heading: expected %0d actual %0d", $time,
                             e.plain, o_plain_heading);
                    errors++;
                end
                if (o_tilt_heading !== e.tilt) begin
                    $display("%0t tilt heading: expected %0d actual %0d", $time,
                             e.tilt, o_tilt_heading);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t watchdog expired with %0d words pending", $time, heading_q.size());
            $display("tb_tilt_compensated_compass_heading NOT OK");
            $finish;
        end
    end

    task automatic send_word(input int sx, input int sy, input int sz, input int p, input int r,
                             input bit typed, input int plain, input int tilt);
        t_heading h;
        i_in_valid <= 1'b1;
        i_sensor_x <= 16'(sx);
        i_sensor_y <= 16'(sy);
        i_sensor_z <= 16'(sz);
        i_pitch_angle <= 16'(p);
        i_roll_angle <= 16'(r);
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        words_in++;
        h = predict_heading(sx, sy, sz, p, r);
        if (typed) begin
            h.plain = 16'(plain);
            h.tilt = 15'(tilt);
        end
        heading_q.push_back(h);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 20);
            if (gap_max > 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(posedge i_clk);
            end
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [2:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        case (idx)
            CFG_FORWARD: fwd_src = v;
            CFG_RIGHT: right_src = v;
            default: up_src = v;
        endcase
    endtask

    task automatic drain_and_idle();
        i_in_valid <= 1'b0;
        while (heading_q.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    function automatic int pick_reading();
        case ($urandom_range(0, 9))
            0: return -32768;
            1: return 32767;
            2: return $urandom_range(0, 2) - 1;
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic int pick_angle();
        case ($urandom_range(0, 9))
            0: return 25736;
            1: return -25736;
            2: return $urandom_range(0, 1) ? 12868 : -12868;
            3: return int'($signed(16'($urandom)));
            default: return int'($urandom_range(0, 51472)) - 25736;
        endcase
    endfunction

    t_row rows[N_ROWS] = '{
        '{0, 0, 0, 0, 0, 1'b1, 0, 0},
        '{32767, 0, 0, 0, 0, 1'b0, 0, 0},
        '{-32768, 0, 0, 0, 0, 1'b0, 0, 0},
        '{0, 32767, 0, 0, 0, 1'b0, 0, 0},
        '{0, -32768, 0, 0, 0, 1'b0, 0, 0},
        '{0, 0, 32767, 25736, 0, 1'b0, 0, 0},
        '{0, 0, -32768, -25736, 0, 1'b0, 0, 0},
        '{1000, -1000, 500, 12868, -12868, 1'b0, 0, 0},
        '{-1, -1, -1, 25736, 25736, 1'b0, 0, 0},
        '{-32768, -32768, -32768, -25736, -25736, 1'b0, 0, 0},
        '{32767, 32767, 32767, 12869, -12869, 1'b0, 0, 0},
        '{0, 0, 0, 0, 0, 1'b0, 0, 0},
        '{5, 5, 5, 100, -100, 1'b0, 0, 0},
        '{-7, 3, 0, -25735, 25735, 1'b0, 0, 0},
        '{300, -200, 100, 32767, -32768, 1'b0, 0, 0}
    };

    int phase_cfg[N_PHASES][3] = '{
        '{1, 3, 5}, '{5, 0, 3}, '{2, 4, 0}, '{6, 7, 1},
        '{7, 6, 2}, '{4, 5, 7}, '{3, 1, 5}, '{0, 2, 4}
    };

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_FORWARD;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_sensor_x = '0;
        i_sensor_y = '0;
        i_sensor_z = '0;
        i_pitch_angle = '0;
        i_roll_angle = '0;
        i_out_stall = 1'b0;
        stall_mode = 0;
        errors = 0;
        words_in = 0;
        words_out = 0;
        idle_cycles = 0;
        burst_left = 0;
        gap_max = 0;
        fwd_src = 3'd0;
        right_src = 3'd2;
        up_src = 3'd4;
        win_slot = 0;
        for (int i = 0; i < WIN; i++) begin
            fwd_win[i] = 0;
            right_win[i] = 0;
            up_win[i] = 0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_ROWS; i++) begin
            send_word(rows[i].x, rows[i].y, rows[i].z, rows[i].p, rows[i].r,
                      rows[i].typed, rows[i].plain, rows[i].tilt);
        end
        drain_and_idle();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            write_reg(CFG_FORWARD, 3'(phase_cfg[ph][0]));
            write_reg(CFG_RIGHT, 3'(phase_cfg[ph][1]));
            write_reg(CFG_UP, 3'(phase_cfg[ph][2]));
            i_cfg_we <= 1'b0;
            stall_mode = ph % 3;
            gap_max = (ph % 4 == 0) ? 0 : 4 * (ph % 4);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                send_word(pick_reading(), pick_reading(), pick_reading(),
                          pick_angle(), pick_angle(), 1'b0, 0, 0);
            end
            drain_and_idle();
        end

        $display("%0d sensor words sent, %0d headings checked, %0d axis mappings",
                 words_in, words_out, N_PHASES + 1);
        if (errors == 0 && heading_q.size() == 0) begin
            $display("tb_tilt_compensated_compass_heading OK");
        end else begin
            $display("tb_tilt_compensated_compass_heading NOT OK");
        end
        $finish;
    end

endmodule

// ----- tilt_compensated_compass_heading.f -----
design/tch_pkg.sv
design/tch_cordic.sv
design/tilt_compensated_compass_heading.sv
verif/tb_tilt_compensated_compass_heading.sv
